// ===== rtl/tba_pkg.sv =====
// Package for the text-to-bytecode assembler: payload structs, scanner codes,
// the job record passed from the scanner to the emitter, and byte constants.
// No dependencies.
package tba_pkg;

  // Depth of the job queue between scanner and emitter.
  localparam int unsigned JobDepth = 4;

  // Machine code bytes.
  localparam logic [7:0] ByteEscape = 8'h0F;
  localparam logic [7:0] BytePush   = 8'h84;
  localparam logic [7:0] ByteInt    = 8'hC2;

  // ASCII characters the scanner recognizes.
  localparam logic [7:0] AsciiZero    = 8'd48;
  localparam logic [7:0] AsciiNine    = 8'd57;
  localparam logic [7:0] AsciiLowA    = 8'd97;
  localparam logic [7:0] AsciiLowZ    = 8'd122;
  localparam logic [7:0] AsciiUpA     = 8'd65;
  localparam logic [7:0] AsciiUpZ     = 8'd90;
  localparam logic [7:0] AsciiSemi    = 8'd59;
  localparam logic [7:0] AsciiSpace   = 8'd32;
  localparam logic [7:0] AsciiNewline = 8'd10;
  localparam logic [7:0] AsciiTab     = 8'd9;
  localparam logic [7:0] AsciiP       = 8'd112;
  localparam logic [7:0] AsciiU       = 8'd117;
  localparam logic [7:0] AsciiS       = 8'd115;
  localparam logic [7:0] AsciiH       = 8'd104;
  localparam logic [7:0] AsciiI       = 8'd105;
  localparam logic [7:0] AsciiN       = 8'd110;
  localparam logic [7:0] AsciiT       = 8'd116;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WORD,
    PH_NUM,
    PH_COMMENT,
    PH_DEAD
  } phase_e;

  // Mnemonic prefix matched so far.
  typedef enum logic [2:0] {
    M_NONE,
    M_P,
    M_PU,
    M_PUS,
    M_PUSH,
    M_I,
    M_IN,
    M_INT
  } match_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_INT
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_TAB,
    ERR_CHAR,
    ERR_DIRECTIVE,
    ERR_WORD,
    ERR_OPERAND,
    ERR_INSTR
  } err_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] source_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       byte_valid;
    logic [2:0] error_code;
    logic       run_last;
    logic       source_done;
  } out_item_t;

  // One scanned input transaction: what to emit and the status to report.
  typedef struct packed {
    op_e         op;
    logic [15:0] operand;
    err_e        err;
    logic        done;
  } job_t;

endpackage

// ===== rtl/tba_front.sv =====
// Scanner of the text-to-bytecode assembler: classifies each source character,
// tracks the token state and writes one job per transaction. Uses tba_pkg.
module tba_front import tba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t in_item_i,
  output logic     job_push_o,
  output job_t     job_o
);

  phase_e      phase_q, phase_d;
  match_e      match_q, match_d;
  op_e         pend_q, pend_d;
  logic [15:0] acc_q, acc_d;
  err_e        err_q, err_d;
  op_e         emit_op;

  logic [7:0] ch;
  logic       is_lower, is_upper, is_digit;
  logic [3:0] digit;

  assign ch       = in_item_i.source_byte;
  assign is_lower = (ch >= AsciiLowA) && (ch <= AsciiLowZ);
  assign is_upper = (ch >= AsciiUpA) && (ch <= AsciiUpZ);
  assign is_digit = (ch >= AsciiZero) && (ch <= AsciiNine);
  assign digit    = 4'(ch - AsciiZero);

  function automatic match_e advance_match(match_e m, logic [7:0] c);
    match_e r;
    r = M_NONE;
    if (m == M_P && c == AsciiU) r = M_PU;
    if (m == M_PU && c == AsciiS) r = M_PUS;
    if (m == M_PUS && c == AsciiH) r = M_PUSH;
    if (m == M_I && c == AsciiN) r = M_IN;
    if (m == M_IN && c == AsciiT) r = M_INT;
    return r;
  endfunction

  always_comb begin : next_state
    logic   cont;
    op_e    wop;
    match_e adv;
    phase_d = phase_q;
    match_d = match_q;
    pend_d  = pend_q;
    acc_d   = acc_q;
    err_d   = err_q;
    emit_op = OP_NONE;
    cont    = 1'b0;
    wop     = OP_NONE;
    adv     = advance_match(match_q, ch);

    if (in_item_i.mode) begin
      // End of source: close the open token, then check for a dangling mnemonic.
      if (err_q == ERR_NONE) begin
        unique case (phase_q) inside
          PH_WORD, PH_DEAD: begin
            // A finished mnemonic would still lack its operand.
            if (pend_q != OP_NONE || (phase_q == PH_WORD &&
                (match_q == M_PUSH || match_q == M_INT))) begin
              err_d = ERR_OPERAND;
            end else begin
              err_d = ERR_WORD;
            end
          end
          PH_NUM: begin
            if (pend_q == OP_NONE) err_d = ERR_INSTR;
            else emit_op = pend_q;
          end
          default: begin
            if (pend_q != OP_NONE) err_d = ERR_OPERAND;
          end
        endcase
      end
      phase_d = PH_IDLE;
      match_d = M_NONE;
      pend_d  = OP_NONE;
      acc_d   = '0;
    end else if (err_q == ERR_NONE) begin
      unique case (phase_q) inside
        PH_COMMENT: begin
          if (ch == AsciiNewline) phase_d = PH_IDLE;
        end
        PH_WORD, PH_DEAD: begin
          if (is_lower || is_upper) begin
            if (phase_q == PH_WORD) begin
              match_d = adv;
              if (adv == M_NONE) phase_d = PH_DEAD;
            end
          end else begin
            phase_d = PH_IDLE;
            match_d = M_NONE;
            if (phase_q == PH_WORD && match_q == M_PUSH) wop = OP_PUSH;
            if (phase_q == PH_WORD && match_q == M_INT) wop = OP_INT;
            if (pend_q != OP_NONE) begin
              err_d = ERR_OPERAND;
            end else if (wop == OP_NONE) begin
              err_d = ERR_WORD;
            end else begin
              pend_d = wop;
              cont   = 1'b1;
            end
          end
        end
        PH_NUM: begin
          if (is_digit) begin
            acc_d = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {12'd0, digit};
          end else begin
            phase_d = PH_IDLE;
            if (pend_q == OP_NONE) begin
              err_d = ERR_INSTR;
            end else begin
              emit_op = pend_q;
              cont    = 1'b1;
            end
            pend_d = OP_NONE;
            acc_d  = '0;
          end
        end
        default: cont = 1'b1;
      endcase

      // The character that ended a token, or one seen between tokens.
      if (cont) begin
        if (is_digit) begin
          phase_d = PH_NUM;
          acc_d   = {12'd0, digit};
        end else if (is_lower) begin
          if (ch == AsciiP) match_d = M_P;
          else if (ch == AsciiI) match_d = M_I;
          else match_d = M_NONE;
          phase_d = (ch == AsciiP || ch == AsciiI) ? PH_WORD : PH_DEAD;
        end else if (is_upper) begin
          err_d = ERR_DIRECTIVE;
        end else if (ch == AsciiSemi) begin
          phase_d = PH_COMMENT;
        end else if (ch == AsciiSpace || ch == AsciiNewline) begin
          // Whitespace between tokens leaves the scanner as it is.
        end else if (ch == AsciiTab) begin
          err_d = ERR_TAB;
        end else begin
          err_d = ERR_CHAR;
        end
      end
    end
  end

  always_comb begin : outputs
    job_push_o      = accept_i;
    job_o.op        = emit_op;
    job_o.operand   = acc_q;
    job_o.err       = err_d;
    job_o.done      = in_item_i.mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      match_q <= M_NONE;
      pend_q  <= OP_NONE;
      acc_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      match_q <= match_d;
      pend_q  <= pend_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== rtl/tba_queue.sv =====
// Job queue between the scanner and the emitter of the assembler.
// Uses tba_pkg for the job record.
module tba_queue import tba_pkg::*; #(
  parameter int unsigned DEPTH = JobDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop) rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/tba_back.sv =====
// Emitter of the assembler: takes one job at a time and plays out its code
// bytes and its status result, one per cycle while popped. Uses tba_pkg.
module tba_back import tba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_pop_o,
  output out_item_t out_item_o,
  output logic      empty_o,
  input  logic      pop_i
);

  job_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] n_bytes;
  logic       at_status, advance;

  always_comb begin
    case (cur_q.op)
      OP_PUSH: n_bytes = 3'd4;
      OP_INT:  n_bytes = 3'd3;
      default: n_bytes = 3'd0;
    endcase
  end

  assign at_status = (idx_q == n_bytes);
  // Load a new job when nothing is held or the status result just left.
  assign advance   = !cur_valid_q || (pop_i && at_status);

  always_comb begin : next_state
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    job_pop_o   = 1'b0;
    if (advance) begin
      cur_valid_d = job_valid_i;
      cur_d       = job_i;
      idx_d       = '0;
      job_pop_o   = job_valid_i;
    end else if (pop_i) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin : outputs
    empty_o                = !cur_valid_q;
    out_item_o.code_byte   = '0;
    out_item_o.byte_valid  = !at_status;
    out_item_o.error_code  = at_status ? cur_q.err : ERR_NONE;
    out_item_o.run_last    = at_status;
    out_item_o.source_done = at_status && cur_q.done;
    if (!at_status) begin
      case (idx_q)
        3'd0:    out_item_o.code_byte = ByteEscape;
        3'd1:    out_item_o.code_byte = (cur_q.op == OP_PUSH) ? BytePush : ByteInt;
        3'd2:    out_item_o.code_byte = cur_q.operand[7:0];
        default: out_item_o.code_byte = cur_q.operand[15:8];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

endmodule

// ===== rtl/text_to_bytecode_assembler_unit.sv =====
// Top level of the streaming text-to-bytecode assembler.
// Instantiates tba_front, tba_queue and tba_back; uses tba_pkg.

// The assembler takes source text one character per input transaction and
// accepts a new transaction in every cycle while full is low. Each input
// transaction yields one status result, preceded by the code bytes of a
// statement when that transaction ends an operand: 0F 84 lo hi for push and
// 0F C2 lo for int. The scanner settles each character in the cycle it is
// accepted and writes a job into a queue of JOB_DEPTH entries; the emitter
// drains that queue into its job register and presents one result per cycle
// while results are popped; the status result of a transaction reaches the
// result ports once its job has passed through the queue and that register.
// Sustained throughput is one input transaction per cycle while results are
// popped, limited by the single result port: a transaction that ends an
// operand occupies it for its code bytes and its status result, and the queue
// absorbs that burst before full rises. Errors are sticky until reset; the
// first error in stream order is reported on every later status result, and
// no bytes are emitted after it. End of source (mode set) closes the open
// token and sets source_done on its status result.
module text_to_bytecode_assembler_unit import tba_pkg::*; #(
  parameter int unsigned JOB_DEPTH = JobDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic job_push, job_pop, job_valid;
  job_t front_job, queue_job;

  // An input transaction is taken whenever the job queue has room.
  assign accept = push && !full;

  tba_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .job_push_o (job_push),
    .job_o      (front_job)
  );

  tba_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (queue_job),
    .valid_o (job_valid)
  );

  tba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_job),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .out_item_o  (out_item_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
